FILE: sv/mrwm_pkg.sv
// shared types, widths and character codes for the media-range wildcard matcher
package mrwm_pkg;

	// field widths of the request and response words
	localparam int CMD_W  = 3;
	localparam int CHAR_W = 8;
	localparam int POS_W  = 5;
	localparam int RES_W  = 2;
	localparam int HELD_W = 5;

	// default table geometry
	localparam int MAX_ENTRIES_DEF = 16;
	localparam int MAX_LEN_DEF     = 32;

	// character codes
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

	// match answers
	localparam logic [RES_W-1:0] RES_NONE  = 2'd0;
	localparam logic [RES_W-1:0] RES_MATCH = 2'd1;
	localparam logic [RES_W-1:0] RES_ALL   = 2'd2;

	// request commands
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 3'd0,
		CMD_CHAR  = 3'd1,
		CMD_END   = 3'd2,
		CMD_RESET = 3'd3,
		CMD_MATCH = 3'd4
	} cmd_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic exec;
		logic scan;
		logic load_out;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic is_match;
		logic scan_done;
	} sts_t;

endpackage

FILE: sv/mrwm_req_if.sv
// request channel: command, character and position with valid/ready
interface mrwm_req_if;
	import mrwm_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [CHAR_W-1:0] char_code;
	logic [POS_W-1:0]  position;

	modport source (output valid, output command, output char_code, output position,
		input ready);
	modport sink (input valid, input command, input char_code, input position,
		output ready);
endinterface

FILE: sv/mrwm_rsp_if.sv
// response channel: match answer, overflow flag and entry count with valid/ready
interface mrwm_rsp_if;
	import mrwm_pkg::*;

	logic              valid;
	logic              ready;
	logic [RES_W-1:0]  match_result;
	logic              overflow_error;
	logic [HELD_W-1:0] entries_held;

	modport source (output valid, output match_result, output overflow_error,
		output entries_held, input ready);
	modport sink (input valid, input match_result, input overflow_error,
		input entries_held, output ready);
endinterface

FILE: sv/mrwm_ram.sv
// generic simple dual-port ram with registered read
module mrwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: sv/mrwm_ctrl.sv
// controller state machine: accept, execute, entry scan and response hand-off
module mrwm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  mrwm_pkg::sts_t sts,
	output mrwm_pkg::ctl_t ctl
);
	import mrwm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_PUSH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ctl.load_in = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = sts.is_match ? ST_SCAN : ST_PUSH;
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end
endmodule

FILE: sv/mrwm_dpath.sv
// datapath: pattern memory, list loader, per-entry lengths and candidate scan
module mrwm_dpath #(
	parameter int MAX_ENTRIES = mrwm_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_LEN     = mrwm_pkg::MAX_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mrwm_pkg::ctl_t                ctl,
	output mrwm_pkg::sts_t                sts,
	input  logic [mrwm_pkg::CMD_W-1:0]    req_command,
	input  logic [mrwm_pkg::CHAR_W-1:0]   req_char_code,
	input  logic [mrwm_pkg::POS_W-1:0]    req_position,
	output logic [mrwm_pkg::RES_W-1:0]    rsp_match_result,
	output logic                          rsp_overflow_error,
	output logic [mrwm_pkg::HELD_W-1:0]   rsp_entries_held
);
	import mrwm_pkg::*;

	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int OFF_W  = $clog2(MAX_LEN + 1);
	localparam int DEPTH  = MAX_ENTRIES * MAX_LEN;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CMP_W  = (OFF_W > POS_W) ? OFF_W : POS_W;

	// captured request word
	cmd_t              cmd_q;
	logic [CHAR_W-1:0] ch_q;
	logic [POS_W-1:0]  pos_q;

	// table state
	logic [CNT_W-1:0]       count_q;
	logic [ADDR_W-1:0]      wbase_q;
	logic [OFF_W-1:0]       woff_q;
	logic                   skip_q;
	logic [MAX_ENTRIES-1:0] flags_q;
	logic [OFF_W-1:0]       lens_q [MAX_ENTRIES];

	// scan state
	logic [CNT_W-1:0]  rd_idx_q;
	logic [ADDR_W-1:0] rbase_q;
	logic              ev_valid_s1;
	logic [IDX_W-1:0]  ev_idx_s1;
	logic              ev_inrange_s1;

	// result registers
	logic [RES_W-1:0]  res_q;
	logic              ovf_q;
	logic [RES_W-1:0]  out_res_q;
	logic              out_ovf_q;
	logic [HELD_W-1:0] out_held_q;

	// decoded actions
	logic full, blank, comma;
	logic do_clear, do_close, do_write, skip_set, skip_clr, do_rearm, do_start, ovf_now;
	logic [IDX_W-1:0] cnt_idx;

	// scan signals
	logic              issue, rd_inrange;
	logic [OFF_W-1:0]  rd_len;
	logic [ADDR_W-1:0] raddr, waddr;
	logic [CHAR_W-1:0] rdata, ev_byte;
	logic              ev_cand, hit_eq, hit_star, star_stop, ev_eq, ev_drop;

	assign full    = (count_q == CNT_W'(MAX_ENTRIES));
	assign blank   = (ch_q == CH_SPACE) || (ch_q == CH_TAB);
	assign comma   = (ch_q == CH_COMMA);
	assign cnt_idx = count_q[IDX_W-1:0];

	// command decode for the execute step
	always_comb begin
		do_clear = 1'b0;
		do_close = 1'b0;
		do_write = 1'b0;
		skip_set = 1'b0;
		skip_clr = 1'b0;
		do_rearm = 1'b0;
		do_start = 1'b0;
		ovf_now  = 1'b0;
		if (ctl.exec) begin
			unique case (cmd_q)
				CMD_CLEAR: do_clear = 1'b1;
				CMD_CHAR: begin
					if (!(skip_q && blank)) begin
						skip_clr = 1'b1;
						if (full) begin
							ovf_now = 1'b1;
						end else if (comma) begin
							do_close = 1'b1;
							skip_set = 1'b1;
						end else if (woff_q == OFF_W'(MAX_LEN)) begin
							ovf_now = 1'b1;
						end else begin
							do_write = 1'b1;
						end
					end
				end
				CMD_END: begin
					if (full) begin
						ovf_now = 1'b1;
					end else begin
						do_close = 1'b1;
						skip_clr = 1'b1;
					end
				end
				CMD_RESET: do_rearm = 1'b1;
				CMD_MATCH: do_start = 1'b1;
				default: ;
			endcase
		end
	end

	// read side of the scan: one entry per cycle
	assign issue      = ctl.scan && (rd_idx_q != count_q);
	assign rd_len     = lens_q[rd_idx_q[IDX_W-1:0]];
	assign rd_inrange = CMP_W'(pos_q) < CMP_W'(rd_len);
	assign raddr      = rbase_q + ADDR_W'(pos_q);
	assign waddr      = wbase_q + ADDR_W'(woff_q);

	mrwm_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_write),
		.waddr (waddr),
		.wdata (ch_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// evaluate side: bytes past the stored length read as zero
	assign ev_byte   = ev_inrange_s1 ? rdata : '0;
	assign ev_cand   = ctl.scan && ev_valid_s1 && flags_q[ev_idx_s1];
	assign hit_eq    = (ev_byte == ch_q);
	assign hit_star  = (ev_byte == CH_STAR);
	assign ev_eq     = ev_cand && hit_eq;
	assign star_stop = ev_cand && !hit_eq && hit_star;
	assign ev_drop   = ev_cand && !hit_eq && !hit_star;

	assign sts.is_match  = (cmd_q == CMD_MATCH);
	assign sts.scan_done = star_stop || (!ev_valid_s1 && (rd_idx_q == count_q));

	// table and scan control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			wbase_q       <= '0;
			woff_q        <= '0;
			skip_q        <= 1'b0;
			flags_q       <= '1;
			rd_idx_q      <= '0;
			rbase_q       <= '0;
			ev_valid_s1   <= 1'b0;
			ev_idx_s1     <= '0;
			ev_inrange_s1 <= 1'b0;
		end else begin
			if (do_clear) begin
				count_q <= '0;
				wbase_q <= '0;
				woff_q  <= '0;
				skip_q  <= 1'b0;
				flags_q <= '1;
			end else begin
				if (do_close) begin
					count_q          <= count_q + 1'b1;
					wbase_q          <= wbase_q + ADDR_W'(MAX_LEN);
					woff_q           <= '0;
					flags_q[cnt_idx] <= 1'b1;
				end else if (do_write) begin
					woff_q <= woff_q + 1'b1;
				end
				if (skip_set) begin
					skip_q <= 1'b1;
				end else if (skip_clr) begin
					skip_q <= 1'b0;
				end
				if (do_rearm) begin
					flags_q <= '1;
				end else if (ev_drop) begin
					flags_q[ev_idx_s1] <= 1'b0;
				end
			end
			// scan pointers
			if (do_start) begin
				rd_idx_q    <= '0;
				rbase_q     <= '0;
				ev_valid_s1 <= 1'b0;
			end else if (ctl.scan) begin
				ev_valid_s1 <= issue;
				if (issue) begin
					rd_idx_q      <= rd_idx_q + 1'b1;
					rbase_q       <= rbase_q + ADDR_W'(MAX_LEN);
					ev_idx_s1     <= rd_idx_q[IDX_W-1:0];
					ev_inrange_s1 <= rd_inrange;
				end
			end
		end
	end

	// request capture, entry lengths and result words
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= cmd_t'(req_command);
			ch_q  <= req_char_code;
			pos_q <= req_position;
		end
		if (do_close) begin
			lens_q[cnt_idx] <= woff_q;
		end
		if (ctl.exec) begin
			res_q <= RES_NONE;
			ovf_q <= ovf_now;
		end else if (star_stop) begin
			res_q <= RES_ALL;
		end else if (ev_eq) begin
			res_q <= RES_MATCH;
		end
		if (ctl.load_out) begin
			out_res_q  <= res_q;
			out_ovf_q  <= ovf_q;
			out_held_q <= HELD_W'(count_q);
		end
	end

	assign rsp_match_result   = out_res_q;
	assign rsp_overflow_error = out_ovf_q;
	assign rsp_entries_held   = out_held_q;
endmodule

FILE: sv/media_range_wildcard_matcher_unit.sv
// top level of the media-range wildcard matcher
//
// Keeps a table of up to MAX_ENTRIES media-range patterns of up to MAX_LEN bytes each,
// loaded one character per request word (a comma closes an entry, blanks and tabs after a
// comma are skipped, list-end closes the last entry). A match word compares one character
// at one position against the candidate entries in index order and answers no match,
// match or wildcard-all. Every request word gives exactly one response word. The block
// takes one request word at a time: a load, clear, list-end or candidate-reset word
// passes through the execute and push states, and a match word also through a scan of the N
// closed entries, which ends early when a '*' stops it. The match time is set by the
// single read port of the pattern memory, which delivers one entry byte per cycle. A new
// request word is taken while the previous response word still waits on the response
// channel. No clearing pass is needed after reset: a per-entry length register makes every
// byte beyond an entry's stored length read as zero.
module media_range_wildcard_matcher_unit #(
	parameter int MAX_ENTRIES = mrwm_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_LEN     = mrwm_pkg::MAX_LEN_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mrwm_req_if.sink   req,
	mrwm_rsp_if.source rsp
);
	import mrwm_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequencing
	mrwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// table, memory and scan
	mrwm_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MAX_LEN     (MAX_LEN)
	) u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.sts                (sts),
		.req_command        (req.command),
		.req_char_code      (req.char_code),
		.req_position       (req.position),
		.rsp_match_result   (rsp.match_result),
		.rsp_overflow_error (rsp.overflow_error),
		.rsp_entries_held   (rsp.entries_held)
	);
endmodule
